[design/sdo_segmented_download_client_defines.svh]
// assertion macros used by the sdo download client core
`ifndef SDO_SEGMENTED_DOWNLOAD_CLIENT_DEFINES_SVH
`define SDO_SEGMENTED_DOWNLOAD_CLIENT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SDO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdo assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SDO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdo assertion failed");

`endif

[design/sdo_pkg.sv]
// types, constants and helpers for the sdo segmented download client
`timescale 1ns / 1ps
package sdo_pkg;

  // default width of the reply timeout counter
  localparam int unsigned TIMEOUT_CNT_W_DEFAULT = 16;

  // stream and config port widths
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  // sdo command bytes and cob-id bases
  localparam logic [7:0]  CMD_EXPEDITED  = 8'h23;
  localparam logic [7:0]  CMD_INITIATE   = 8'h21;
  localparam logic [7:0]  CMD_KIND_MASK  = 8'hE0;
  localparam logic [7:0]  KIND_ABORT     = 8'h80;
  localparam logic [7:0]  KIND_INIT_RESP = 8'h60;
  localparam logic [7:0]  KIND_SEG_RESP  = 8'h20;
  localparam logic [10:0] COB_RSDO_BASE  = 11'h600;
  localparam logic [10:0] COB_TSDO_BASE  = 11'h580;
  localparam logic [10:0] COB_MASK       = 11'h7FF;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_SEGMENT  = 2'd1,
    OP_RX_FRAME = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_WAIT    = 4'd0,
    ST_NEED    = 4'd1,
    ST_DONE    = 4'd2,
    ST_ABORT   = 4'd3,
    ST_BAD     = 4'd4,
    ST_TOGGLE  = 4'd5,
    ST_COBID   = 4'd6,
    ST_TIMEOUT = 4'd7,
    ST_MISUSE  = 4'd8
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ID = 4'd0,
    CFG_TIMEOUT = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]  node_id;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] od_index;
    logic [7:0]  od_subindex;
    logic [31:0] total_length;
    logic [55:0] payload;
    logic [10:0] rx_cob_id;
    logic [63:0] rx_frame;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_cob_id;
    logic [63:0] tx_frame;
    status_e     status;
    logic [31:0] abort_code;
    logic [31:0] bytes_sent;
  } res_t;

  // keep the low n bytes of a seven byte field
  function automatic logic [55:0] byte_mask(input logic [2:0] n);
    logic [55:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

[design/sdo_cfg.sv]
// configuration registers: server node id and reply timeout
`timescale 1ns / 1ps
module sdo_cfg
  import sdo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ID: cfg_d.node_id       = cfg_data_i[6:0];
        CFG_TIMEOUT: cfg_d.timeout_ticks = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id       <= 7'd10;
      cfg_q.timeout_ticks <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/sdo_in_stage.sv]
// input register holding one accepted beat until the core takes it
`timescale 1ns / 1ps
module sdo_in_stage
  import sdo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // room when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[design/sdo_out_stage.sv]
// result register toward the master side
`timescale 1ns / 1ps
module sdo_out_stage
  import sdo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // slot is free when empty or being drained now
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[design/sdo_core.sv]
// transfer state machine: builds request frames and checks responses
`timescale 1ns / 1ps
module sdo_core
  import sdo_pkg::*;
#(
  parameter int unsigned TIMEOUT_COUNTER_WIDTH = TIMEOUT_CNT_W_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  go_i,
  input  item_t item_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned TW = TIMEOUT_COUNTER_WIDTH;
  localparam logic [31:0] WaitMax = 32'((64'd1 << TW) - 64'd1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_EXP,
    PH_WAIT_INI,
    PH_NEED_SEG,
    PH_WAIT_SEG
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [31:0]   length_q, length_d;
  logic [31:0]   offset_q, offset_d;
  logic          toggle_q, toggle_d;
  logic [2:0]    pend_q, pend_d;
  logic [TW-1:0] wait_q, wait_d;

  logic          waiting;
  logic [TW-1:0] wait_load;
  logic [31:0]   ticks_ext;
  logic [31:0]   remaining;
  logic [2:0]    seg_n;
  logic          seg_last;
  logic [7:0]    exp_cmd;
  logic [7:0]    seg_cmd;
  logic [55:0]   exp_mask;
  logic [31:0]   exp_data;
  logic [55:0]   seg_data;
  logic [7:0]    rx_cmd;
  logic [7:0]    rx_kind;
  logic [10:0]   rx_expect;
  logic [31:0]   seg_offset;
  logic          res_valid;
  logic          tx_valid;
  logic [63:0]   tx_frame;
  status_e       status;
  logic [31:0]   abort_code;

  // reply timer load, saturated to the counter width
  assign ticks_ext = {16'd0, cfg_i.timeout_ticks};
  assign wait_load = (ticks_ext > WaitMax) ? WaitMax[TW-1:0] : ticks_ext[TW-1:0];

  assign waiting = (phase_q == PH_WAIT_EXP) || (phase_q == PH_WAIT_INI) ||
                   (phase_q == PH_WAIT_SEG);

  // expedited request byte zero and data
  assign exp_cmd  = CMD_EXPEDITED |
                    {4'd0, 2'(3'd4 - item_i.total_length[2:0]), 2'd0};
  assign exp_mask = byte_mask(item_i.total_length[2:0]);
  assign exp_data = item_i.payload[31:0] & exp_mask[31:0];

  // segment size, last flag and byte zero
  assign remaining  = length_q - offset_q;
  assign seg_n      = (remaining > 32'd7) ? 3'd7 : remaining[2:0];
  assign seg_last   = ({1'b0, offset_q} + 33'(seg_n)) >= {1'b0, length_q};
  assign seg_cmd    = {3'd0, toggle_q, 3'(3'd7 - seg_n), seg_last};
  assign seg_data   = item_i.payload & byte_mask(seg_n);

  // response decode
  assign rx_cmd     = item_i.rx_frame[7:0];
  assign rx_kind    = rx_cmd & CMD_KIND_MASK;
  assign rx_expect  = (COB_TSDO_BASE + {4'd0, cfg_i.node_id}) & COB_MASK;
  assign seg_offset = offset_q + 32'(pend_q);

  // next state and result for the item at the head of the input register
  always_comb begin
    phase_d    = phase_q;
    length_d   = length_q;
    offset_d   = offset_q;
    toggle_d   = toggle_q;
    pend_d     = pend_q;
    wait_d     = wait_q;
    res_valid  = 1'b0;
    tx_valid   = 1'b0;
    tx_frame   = '0;
    status     = ST_WAIT;
    abort_code = '0;
    case (item_i.op)
      OP_START: begin
        res_valid = 1'b1;
        if (phase_q != PH_IDLE) begin
          status  = ST_MISUSE;
          phase_d = PH_IDLE;
        end else if (item_i.total_length == 32'd0) begin
          status = ST_MISUSE;
        end else begin
          length_d = item_i.total_length;
          offset_d = '0;
          toggle_d = 1'b0;
          pend_d   = '0;
          wait_d   = wait_load;
          tx_valid = 1'b1;
          if (item_i.total_length <= 32'd4) begin
            tx_frame = {exp_data, item_i.od_subindex, item_i.od_index, exp_cmd};
            phase_d  = PH_WAIT_EXP;
          end else begin
            tx_frame = {item_i.total_length, item_i.od_subindex, item_i.od_index,
                        CMD_INITIATE};
            phase_d  = PH_WAIT_INI;
          end
        end
      end
      OP_SEGMENT: begin
        res_valid = 1'b1;
        if (phase_q != PH_NEED_SEG) begin
          status  = ST_MISUSE;
          phase_d = PH_IDLE;
        end else begin
          tx_valid = 1'b1;
          tx_frame = {seg_data, seg_cmd};
          pend_d   = seg_n;
          phase_d  = PH_WAIT_SEG;
          wait_d   = wait_load;
        end
      end
      OP_TICK: begin
        if (waiting) begin
          if (wait_q <= TW'(1)) begin
            wait_d    = '0;
            res_valid = 1'b1;
            status    = ST_TIMEOUT;
            phase_d   = PH_IDLE;
          end else begin
            wait_d = wait_q - TW'(1);
          end
        end
      end
      OP_RX_FRAME: begin
        if (waiting) begin
          res_valid = 1'b1;
          phase_d   = PH_IDLE;
          if (item_i.rx_cob_id != rx_expect) begin
            status = ST_COBID;
          end else if (rx_kind == KIND_ABORT) begin
            status     = ST_ABORT;
            abort_code = item_i.rx_frame[63:32];
          end else if (phase_q == PH_WAIT_EXP) begin
            if (rx_kind != KIND_INIT_RESP) begin
              status = ST_BAD;
            end else begin
              offset_d = length_q;
              status   = ST_DONE;
            end
          end else if (phase_q == PH_WAIT_INI) begin
            if (rx_kind != KIND_INIT_RESP) begin
              status = ST_BAD;
            end else begin
              phase_d = PH_NEED_SEG;
              status  = ST_NEED;
            end
          end else if (rx_kind != KIND_SEG_RESP) begin
            status = ST_BAD;
          end else if (rx_cmd[4] != toggle_q) begin
            status = ST_TOGGLE;
          end else begin
            offset_d = seg_offset;
            toggle_d = ~toggle_q;
            if (seg_offset >= length_q) begin
              status = ST_DONE;
            end else begin
              phase_d = PH_NEED_SEG;
              status  = ST_NEED;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result fields
  assign res_valid_o      = go_i && res_valid;
  assign res_o.tx_valid   = tx_valid;
  assign res_o.tx_cob_id  = tx_valid ? ((COB_RSDO_BASE + {4'd0, cfg_i.node_id}) & COB_MASK)
                                     : 11'd0;
  assign res_o.tx_frame   = tx_frame;
  assign res_o.status     = status;
  assign res_o.abort_code = abort_code;
  assign res_o.bytes_sent = offset_d;

  // transfer state, advanced once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      length_q <= '0;
      offset_q <= '0;
      toggle_q <= 1'b0;
      pend_q   <= '0;
      wait_q   <= '0;
    end else if (go_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      offset_q <= offset_d;
      toggle_q <= toggle_d;
      pend_q   <= pend_d;
      wait_q   <= wait_d;
    end
  end

`include "sdo_segmented_download_client_defines.svh"

  `SDO_ASSERT_NXT(a_state_holds, !go_i, $stable(phase_q) && $stable(offset_q))
  `SDO_ASSERT_IMP(a_offset_bound, 1'b1, offset_q <= length_q)
  `SDO_ASSERT_IMP(a_need_left, phase_q == PH_NEED_SEG, offset_q < length_q)
  `SDO_ASSERT_NXT(a_sent_waits, go_i && res_valid && tx_valid,
                  phase_q == PH_WAIT_EXP || phase_q == PH_WAIT_INI ||
                  phase_q == PH_WAIT_SEG)

endmodule

[design/sdo_segmented_download_client.sv]
// Top level of the CANopen SDO segmented download client.
//
// Slave stream (s_axis_*) carries request items: tuser is the operation
// (start, segment data, received frame, tick), tdata the operands.
// Master stream (m_axis_*) carries one result beat per item that produces
// one; tuser flags a request frame to send, tdata holds the frame, status,
// abort code and acknowledged byte count.
// The cfg_* channel writes node id (index 0) and reply timeout (index 1);
// it is always ready and should be written while no item is in flight.
//
// An accepted item is held in the input register and decided by the core once
// the result register is free; its result is registered there for m_axis.
// Throughput: one item per cycle while m_axis_tready is high, set by the
// combinational decision logic between the input register and the result register.
// Reset: all transfer state returns to idle, both stream registers empty,
// node id back to 10 and timeout to 1000 ticks.
// Stall: while m_axis_tready is low and a result is held, the input register
// keeps one item and s_axis_tready drops once it is full.
`timescale 1ns / 1ps
module sdo_segmented_download_client
  import sdo_pkg::*;
#(
  parameter int unsigned TIMEOUT_COUNTER_WIDTH = TIMEOUT_CNT_W_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // od_index, od_subindex, total_length, payload, rx_cob_id, rx_frame, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]             s_axis_tuser,
  // master stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tx_cob_id, tx_frame, status, abort_code, bytes_sent, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tx_valid
  output logic [0:0]             m_axis_tuser,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t  cfg;
  item_t in_item;
  item_t head_item;
  logic  head_valid;
  logic  out_free;
  logic  go;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // unpack the slave beat
  assign in_item.op           = op_e'(s_axis_tuser);
  assign in_item.od_index     = s_axis_tdata[15:0];
  assign in_item.od_subindex  = s_axis_tdata[23:16];
  assign in_item.total_length = s_axis_tdata[55:24];
  assign in_item.payload      = s_axis_tdata[111:56];
  assign in_item.rx_cob_id    = s_axis_tdata[122:112];
  assign in_item.rx_frame     = s_axis_tdata[186:123];

  // the head item is processed when the result slot can take it
  assign go = head_valid && out_free;

  sdo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdo_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (go),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  sdo_core #(
    .TIMEOUT_COUNTER_WIDTH (TIMEOUT_COUNTER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .go_i        (go),
    .item_i      (head_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdo_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the master beat
  assign m_axis_tuser = out_res.tx_valid;
  assign m_axis_tdata = {1'b0, out_res.bytes_sent, out_res.abort_code,
                         out_res.status, out_res.tx_frame, out_res.tx_cob_id};

endmodule

[dv/sdo_client_monitor.sv]
// stream monitor that predicts and checks the sdo download client result beats
`timescale 1ns / 1ps
module sdo_client_monitor
  import sdo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream as seen at the block
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [1:0]             s_tuser_i,
  // result stream as seen at the block
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [0:0]             m_tuser_i,
  // register writes
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned            failures_o,
  output int unsigned            pending_o
);

  typedef enum logic [2:0] {
    XFER_IDLE,
    XFER_WAIT_EXP,
    XFER_WAIT_INI,
    XFER_NEED_SEG,
    XFER_WAIT_SEG
  } xfer_e;

  // shadow registers
  logic [6:0]  node_id;
  logic [15:0] timeout_ticks;

  // shadow transfer state
  xfer_e       xfer;
  logic [31:0] length_total;
  logic [31:0] byte_offset;
  logic        toggle;
  logic [2:0]  seg_len;
  logic [15:0] wait_cnt;

  res_t        predicted_results[$];
  int unsigned fail_count;
  item_t       seen;
  res_t        want;
  res_t        got;

  // one result beat as the client state stands now
  function automatic res_t client_reply(input logic tx, input logic [63:0] frame,
                                        input status_e st, input logic [31:0] abort);
    res_t r;
    r.tx_valid   = tx;
    r.tx_cob_id  = tx ? ((COB_RSDO_BASE + 11'(node_id)) & COB_MASK) : '0;
    r.tx_frame   = tx ? frame : '0;
    r.status     = st;
    r.abort_code = abort;
    r.bytes_sent = byte_offset;
    return r;
  endfunction

  // any error drops the transfer
  function automatic res_t error_reply(input status_e st, input logic [31:0] abort);
    xfer = XFER_IDLE;
    return client_reply(1'b0, '0, st, abort);
  endfunction

  // advance the shadow client by one item, returns 1 when a beat is due
  function automatic bit predict_client_result(input item_t it, output res_t r);
    logic [63:0] frame;
    logic [63:0] keep;
    logic [31:0] remaining;
    logic [2:0]  n;
    logic        last;
    logic [7:0]  cmd;
    logic [7:0]  kind;
    r = '0;
    frame = '0;
    case (it.op)
      OP_START: begin
        if (xfer != XFER_IDLE) begin
          r = error_reply(ST_MISUSE, '0);
          return 1'b1;
        end
        if (it.total_length == 32'd0) begin
          r = client_reply(1'b0, '0, ST_MISUSE, '0);
          return 1'b1;
        end
        frame[31:8]  = {it.od_subindex, it.od_index};
        length_total = it.total_length;
        byte_offset  = '0;
        toggle       = 1'b0;
        seg_len      = '0;
        if (it.total_length <= 32'd4) begin
          // expedited: size coded as unused bytes
          keep          = (64'd1 << (8 * it.total_length)) - 64'd1;
          frame[7:0]    = CMD_EXPEDITED | 8'((32'd4 - it.total_length) << 2);
          frame[63:32]  = 32'(64'(it.payload) & keep);
          xfer          = XFER_WAIT_EXP;
        end else begin
          frame[7:0]   = CMD_INITIATE;
          frame[63:32] = it.total_length;
          xfer         = XFER_WAIT_INI;
        end
        wait_cnt = timeout_ticks;
        r = client_reply(1'b1, frame, ST_WAIT, '0);
        return 1'b1;
      end
      OP_SEGMENT: begin
        if (xfer != XFER_NEED_SEG) begin
          r = error_reply(ST_MISUSE, '0);
          return 1'b1;
        end
        remaining = length_total - byte_offset;
        n = (remaining > 32'd7) ? 3'd7 : remaining[2:0];
        last = ({1'b0, byte_offset} + 33'(n)) >= {1'b0, length_total};
        keep = (64'd1 << (8 * n)) - 64'd1;
        frame[7:0]  = {3'b000, toggle, 3'd7 - n, last};
        frame[63:8] = 56'(64'(it.payload) & keep);
        seg_len  = n;
        xfer     = XFER_WAIT_SEG;
        wait_cnt = timeout_ticks;
        r = client_reply(1'b1, frame, ST_WAIT, '0);
        return 1'b1;
      end
      default: begin
        // frames and ticks only matter while a reply is awaited
        if (xfer == XFER_IDLE || xfer == XFER_NEED_SEG) return 1'b0;
        if (it.op == OP_TICK) begin
          if (wait_cnt <= 16'd1) begin
            wait_cnt = '0;
            r = error_reply(ST_TIMEOUT, '0);
            return 1'b1;
          end
          wait_cnt = wait_cnt - 16'd1;
          return 1'b0;
        end
        cmd  = it.rx_frame[7:0];
        kind = cmd & CMD_KIND_MASK;
        if (it.rx_cob_id != ((COB_TSDO_BASE + 11'(node_id)) & COB_MASK)) begin
          r = error_reply(ST_COBID, '0);
          return 1'b1;
        end
        if (kind == KIND_ABORT) begin
          r = error_reply(ST_ABORT, it.rx_frame[63:32]);
          return 1'b1;
        end
        if (xfer == XFER_WAIT_EXP || xfer == XFER_WAIT_INI) begin
          if (kind != KIND_INIT_RESP) begin
            r = error_reply(ST_BAD, '0);
            return 1'b1;
          end
          if (xfer == XFER_WAIT_EXP) begin
            byte_offset = length_total;
            xfer = XFER_IDLE;
            r = client_reply(1'b0, '0, ST_DONE, '0);
          end else begin
            xfer = XFER_NEED_SEG;
            r = client_reply(1'b0, '0, ST_NEED, '0);
          end
          return 1'b1;
        end
        // segment response
        if (kind != KIND_SEG_RESP) begin
          r = error_reply(ST_BAD, '0);
          return 1'b1;
        end
        if (cmd[4] != toggle) begin
          r = error_reply(ST_TOGGLE, '0);
          return 1'b1;
        end
        byte_offset = byte_offset + 32'(seg_len);
        toggle = ~toggle;
        if (byte_offset >= length_total) begin
          xfer = XFER_IDLE;
          r = client_reply(1'b0, '0, ST_DONE, '0);
        end else begin
          xfer = XFER_NEED_SEG;
          r = client_reply(1'b0, '0, ST_NEED, '0);
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  // watch all three channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id       = 7'd10;
      timeout_ticks = 16'd1000;
      xfer          = XFER_IDLE;
      length_total  = '0;
      byte_offset   = '0;
      toggle        = 1'b0;
      seg_len       = '0;
      wait_cnt      = '0;
      fail_count    = 0;
      predicted_results.delete();
      failures_o <= 0;
      pending_o  <= 0;
    end else begin
      // result beat against oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got.tx_valid   = m_tuser_i[0];
        got.tx_cob_id  = m_tdata_i[10:0];
        got.tx_frame   = m_tdata_i[74:11];
        got.status     = status_e'(m_tdata_i[78:75]);
        got.abort_code = m_tdata_i[110:79];
        got.bytes_sent = m_tdata_i[142:111];
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing predicted: status %0d", got.status);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_cob_id", want.tx_cob_id, got.tx_cob_id);
          check_field("tx_frame", want.tx_frame, got.tx_frame);
          check_field("status", want.status, got.status);
          check_field("abort_code", want.abort_code, got.abort_code);
          check_field("bytes_sent", want.bytes_sent, got.bytes_sent);
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NODE_ID: node_id = cfg_data_i[6:0];
          CFG_TIMEOUT: timeout_ticks = cfg_data_i;
          default: ;
        endcase
      end
      // input beat through the shadow client
      if (s_tvalid_i && s_tready_i) begin
        seen.op           = op_e'(s_tuser_i);
        seen.od_index     = s_tdata_i[15:0];
        seen.od_subindex  = s_tdata_i[23:16];
        seen.total_length = s_tdata_i[55:24];
        seen.payload      = s_tdata_i[111:56];
        seen.rx_cob_id    = s_tdata_i[122:112];
        seen.rx_frame     = s_tdata_i[186:123];
        if (predict_client_result(seen, want)) predicted_results.push_back(want);
      end
      failures_o <= fail_count;
      pending_o  <= predicted_results.size();
    end
  end

endmodule

[dv/testbench.sv]
// top of the sdo download client testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import sdo_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            failures;
  int unsigned            pending;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          items_sent;
  logic [6:0]  node_cur;
  logic [15:0] timeout_cur;

  sdo_segmented_download_client uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  sdo_client_monitor client_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side backpressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // item builders, every field random unless set
  function automatic item_t random_item();
    item_t it;
    it.op           = op_e'(2'($urandom));
    it.od_index     = 16'($urandom);
    it.od_subindex  = 8'($urandom);
    it.total_length = $urandom;
    it.payload      = 56'({$urandom, $urandom});
    it.rx_cob_id    = 11'($urandom);
    it.rx_frame     = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t start_item(input logic [31:0] len);
    item_t it;
    it = random_item();
    it.op = OP_START;
    it.total_length = len;
    return it;
  endfunction

  function automatic item_t seg_item();
    item_t it;
    it = random_item();
    it.op = OP_SEGMENT;
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = random_item();
    it.op = OP_TICK;
    return it;
  endfunction

  // tick or frame, for times when the client ignores both
  function automatic item_t ignored_item();
    item_t it;
    it = random_item();
    it.op = $urandom_range(1) ? OP_TICK : OP_RX_FRAME;
    return it;
  endfunction

  // server response from the configured node
  function automatic item_t reply_item(input logic [7:0] cmd);
    item_t it;
    it = random_item();
    it.op = OP_RX_FRAME;
    it.rx_cob_id = (COB_TSDO_BASE + 11'(node_cur)) & COB_MASK;
    it.rx_frame[7:0] = cmd;
    return it;
  endfunction

  function automatic item_t wrong_cob_item();
    item_t it;
    it = reply_item(8'($urandom));
    while (it.rx_cob_id == ((COB_TSDO_BASE + 11'(node_cur)) & COB_MASK))
      it.rx_cob_id = 11'($urandom);
    return it;
  endfunction

  // command byte of the given kind and toggle, low bits random
  function automatic logic [7:0] reply_cmd(input logic [7:0] kind, input logic tgl);
    return {kind[7:5], tgl, 4'($urandom)};
  endfunction

  // command byte of neither the wanted kind nor abort
  function automatic logic [7:0] bad_cmd(input logic [7:0] wanted);
    logic [7:0] cmd;
    cmd = 8'($urandom);
    while ((cmd & CMD_KIND_MASK) == wanted || (cmd & CMD_KIND_MASK) == KIND_ABORT)
      cmd = 8'($urandom);
    return cmd;
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send(input item_t it, input bit counted = 1'b1);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= {5'd0, it.rx_frame, it.rx_cob_id, it.payload, it.total_length,
                 it.od_subindex, it.od_index};
    s_tuser  <= it.op;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  // stop sending and let every predicted beat come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    wait_drained();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODE_ID) node_cur = val[6:0];
    else timeout_cur = val;
  endtask

  // while a reply is awaited: some ticks, or now and then an error that ends the transfer
  task automatic hold_or_break(input bit in_seg, input logic tgl, input bit force_end,
                               output bit ended);
    int ticks;
    ended = 1'b1;
    if (force_end || $urandom_range(99) < 5) begin
      case ($urandom_range(in_seg ? 6 : 5))
        0: send(wrong_cob_item());
        1: send(reply_item(reply_cmd(KIND_ABORT, 1'($urandom))));
        2: send(reply_item(bad_cmd(in_seg ? KIND_SEG_RESP : KIND_INIT_RESP)));
        3: begin
          if (timeout_cur <= 16'd4) repeat (timeout_cur) send(tick_item());
          else send(seg_item());
        end
        4: send(start_item($urandom));
        5: send(seg_item());
        default: send(reply_item(reply_cmd(KIND_SEG_RESP, ~tgl)));
      endcase
      return;
    end
    ticks = ($urandom_range(99) < 85) ? 0 : $urandom_range(2, 1);
    if (ticks >= timeout_cur) begin
      repeat (timeout_cur) send(tick_item());
      return;
    end
    repeat (ticks) send(tick_item());
    ended = 1'b0;
  endtask

  // one download, mostly well formed
  task automatic run_transfer();
    logic [31:0] len;
    logic [31:0] left;
    logic        tgl;
    bit          ended;
    int          segs;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35) len = $urandom_range(4, 1);
    else if (pick < 88) len = $urandom_range(40, 5);
    else if (pick < 95) len = $urandom_range(200, 41);
    else len = $urandom;
    send(start_item(len));
    if (len == 32'd0) return;
    hold_or_break(1'b0, 1'b0, 1'b0, ended);
    if (ended) return;
    send(reply_item(reply_cmd(KIND_INIT_RESP, 1'($urandom))));
    if (len <= 32'd4) return;
    left = len;
    tgl  = 1'b0;
    segs = 0;
    while (left != 0) begin
      if ($urandom_range(99) < 8) send(ignored_item(), 1'b0);
      send(seg_item());
      segs++;
      // very long downloads get cut short
      hold_or_break(1'b1, tgl, segs > 30, ended);
      if (ended) return;
      send(reply_item(reply_cmd(KIND_SEG_RESP, tgl)));
      left = left - ((left > 32'd7) ? 32'd7 : left);
      tgl  = ~tgl;
    end
  endtask

  task automatic random_phase(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      // stray items while idle
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0: send(ignored_item(), 1'b0);
          1: send(seg_item());
          default: send(start_item(32'd0));
        endcase
      end
      run_transfer();
    end
  endtask

  // stimulus and verdict
  initial begin
    item_t it;
    rst_ni = 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    items_sent    = 0;
    node_cur      = 7'd10;
    timeout_cur   = 16'd1000;
    send_idle_pct = 34;
    recv_idle_pct = 47;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle: tick and frame ignored, zero length and stray segment refused
    send(tick_item());
    send(reply_item(reply_cmd(KIND_INIT_RESP, 1'b0)));
    send(start_item(32'd0));
    send(seg_item());
    // one byte expedited at the top of the index range
    it = start_item(32'd1);
    it.od_index    = 16'hFFFF;
    it.od_subindex = 8'hFF;
    it.payload     = '1;
    send(it);
    send(reply_item(KIND_INIT_RESP));
    // start while busy
    it = start_item(32'd4);
    it.od_index    = '0;
    it.od_subindex = '0;
    send(it);
    send(start_item(32'd3));
    // abort with all ones code
    send(start_item(32'd2));
    it = reply_item(KIND_ABORT);
    it.rx_frame[63:32] = 32'hFFFF_FFFF;
    send(it);
    // foreign node, then wrong response type
    send(start_item(32'd3));
    send(wrong_cob_item());
    send(start_item(32'd4));
    send(reply_item(KIND_SEG_RESP));
    // largest length, wrong toggle on the first segment
    send(start_item(32'hFFFF_FFFF));
    send(reply_item(KIND_INIT_RESP));
    send(seg_item());
    send(reply_item(KIND_SEG_RESP | 8'h10));
    // two segments, full then last
    send(start_item(32'd8));
    send(reply_item(KIND_INIT_RESP));
    send(tick_item());
    send(seg_item());
    send(reply_item(KIND_SEG_RESP));
    send(seg_item());
    send(reply_item(KIND_SEG_RESP | 8'h10));
    // shortest timeout, highest node
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_NODE_ID, 16'd127);
    send(start_item(32'd5));
    send(tick_item());
    send(start_item(32'd2));
    send(reply_item(KIND_INIT_RESP));

    // random traffic, both sides stalling
    write_reg(CFG_NODE_ID, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd4);
    random_phase(370);

    // swapped stall rates, longest timeout
    send_idle_pct = 47;
    recv_idle_pct = 34;
    write_reg(CFG_NODE_ID, 16'($urandom_range(126, 2)));
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    random_phase(370);

    // no stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_NODE_ID, 16'($urandom_range(127, 1)));
    write_reg(CFG_TIMEOUT, 16'd2);
    random_phase(370);

    wait_drained();
    if (failures == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/sdo_pkg.sv
design/sdo_cfg.sv
design/sdo_in_stage.sv
design/sdo_out_stage.sv
design/sdo_core.sv
design/sdo_segmented_download_client.sv
dv/sdo_client_monitor.sv
dv/testbench.sv
